// File: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ciss_pkg.sv
`default_nettype none
package ciss_pkg;

	localparam int TEXT_DEPTH_DEF = 256;
	localparam int TERM_DEPTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_CLR_TEXT = 3'd0,
		CMD_APP_TEXT = 3'd1,
		CMD_CLR_TERM = 3'd2,
		CMD_APP_TERM = 3'd3,
		CMD_FWD      = 3'd4,
		CMD_BWD      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_FOUND = 2'd2,
		STAT_NONE  = 2'd3
	} status_t;

	// control broadcast along the cell row
	typedef struct packed {
		logic       load;
		logic       step;
		logic       flush;
		logic [7:0] data;
	} chain_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/ciss_req_if.sv
`default_nettype none
interface ciss_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] data_byte;
	logic [7:0] start_index;

	modport source (output valid, output command, output data_byte, output start_index,
		input ready);
	modport sink (input valid, input command, input data_byte, input start_index,
		output ready);
endinterface
`default_nettype wire

// File: design/ciss_rsp_if.sv
`default_nettype none
interface ciss_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] match_index;

	modport source (output valid, output status, output match_index, input ready);
	modport sink (input valid, input status, input match_index, output ready);
endinterface
`default_nettype wire

// File: design/ciss_cell.sv
`default_nettype none
module ciss_cell import ciss_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire chain_ctl_t ctl,
	input  wire logic       active,
	input  wire logic [7:0] term_in,
	input  wire logic       flag_in,
	output logic [7:0]      term_out,
	output logic            flag_out
);

	logic [7:0] term_q;
	logic       flag_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			term_q <= term_in;
		end
	end

	// partial match: all term bytes up to this cell agree so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.flush) begin
			flag_q <= 1'b0;
		end else if (ctl.step) begin
			flag_q <= flag_in & (~active | (fold_byte(ctl.data) == fold_byte(term_q)));
		end
	end

	assign term_out = term_q;
	assign flag_out = flag_q;

endmodule
`default_nettype wire

// File: design/ciss_chain.sv
`default_nettype none
module ciss_chain import ciss_pkg::*; #(
	parameter  int TERM_DEPTH = TERM_DEPTH_DEF,
	localparam int TLW        = $clog2(TERM_DEPTH + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire chain_ctl_t     ctl,
	input  wire logic [TLW-1:0] term_len,
	output logic                hit
);

	// term is right-aligned: the last cell holds the last term byte
	logic [TERM_DEPTH-1:0] active;
	logic [TERM_DEPTH-1:0] flag_w;
	logic [TERM_DEPTH-1:0] flag_in_w;
	logic [7:0]            term_w    [TERM_DEPTH];
	logic [7:0]            term_in_w [TERM_DEPTH];

	for (genvar j = 0; j < TERM_DEPTH; j++) begin : g_cell
		localparam int unsigned R = TERM_DEPTH - 1 - j;

		assign active[j] = (TLW'(R) < term_len);

		if (j == TERM_DEPTH - 1) begin : g_tail
			assign term_in_w[j] = ctl.data;
		end else begin : g_body
			assign term_in_w[j] = term_w[j+1];
		end

		if (j == 0) begin : g_head
			assign flag_in_w[j] = 1'b1;
		end else begin : g_link
			assign flag_in_w[j] = active[j-1] ? flag_w[j-1] : 1'b1;
		end

		ciss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.active   (active[j]),
			.term_in  (term_in_w[j]),
			.flag_in  (flag_in_w[j]),
			.term_out (term_w[j]),
			.flag_out (flag_w[j])
		);
	end

	assign hit = flag_w[TERM_DEPTH-1];

endmodule
`default_nettype wire

// File: design/case_insensitive_term_search.sv
// Loads, clears, unused commands and searches with an empty term: result in the cycle after the request.
// Search: text bytes stream from the text memory, one a cycle, through the term cell row;
//   a forward search ends at its first hit, otherwise all of its bytes are
//   scanned (forward len - start, backward min(start+L, len)).
// One request at a time; the next is taken once the result slot is free or being drained.
// Reset (async, active low) clears both lengths and all control; store contents stay undefined.
`default_nettype none
module case_insensitive_term_search import ciss_pkg::*; #(
	parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
	parameter int TERM_DEPTH = TERM_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ciss_req_if.sink   request,
	ciss_rsp_if.source result
);

	localparam int AW = $clog2(TEXT_DEPTH);
	localparam int LW = $clog2(TEXT_DEPTH + 1);
	localparam int TLW = $clog2(TERM_DEPTH + 1);
	localparam int MW = (LW > TLW) ? LW : TLW;
	localparam int CW = ((MW > 8) ? MW : 8) + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t         state_q;
	logic [LW-1:0]  text_len_q;
	logic [TLW-1:0] term_len_q;
	logic [7:0]     mem_q [TEXT_DEPTH];

	logic [CW-1:0]  t_q, end_q, t_s1, t_s2;
	logic           v_s1, v_s2;
	logic [7:0]     rd_s1;
	logic           bwd_q, found_q;
	logic [7:0]     last_pos_q;

	logic           out_valid_q;
	status_t        out_status_q;
	logic [7:0]     out_index_q;

	cmd_t           cmd;
	logic           accept, text_full, term_full, term_empty;
	logic [CW-1:0]  s_ext, tl_ext, l_ext, tl_m1, s_plus_l, bwd_end, pos_full;
	status_t        imm_status;
	logic [7:0]     imm_index;
	logic           go_run, issue, hit, chain_hit, finish;
	status_t        fin_status;
	logic [7:0]     fin_index;
	chain_ctl_t     ctl;

	assign cmd        = cmd_t'(request.command);
	assign request.ready = (state_q == S_IDLE) && (!out_valid_q || result.ready);
	assign accept     = request.valid && request.ready;
	assign text_full  = (text_len_q == LW'(TEXT_DEPTH));
	assign term_full  = (term_len_q == TLW'(TERM_DEPTH));
	assign term_empty = (term_len_q == '0);

	assign s_ext    = CW'(request.start_index);
	assign tl_ext   = CW'(text_len_q);
	assign l_ext    = CW'(term_len_q);
	assign tl_m1    = tl_ext - CW'(1);
	assign s_plus_l = s_ext + l_ext;
	assign bwd_end  = (s_plus_l < tl_ext) ? s_plus_l : tl_ext;

	always_comb begin
		imm_status = STAT_OK;
		imm_index  = '0;
		go_run     = 1'b0;
		unique case (cmd)
			CMD_CLR_TEXT, CMD_CLR_TERM: begin
				imm_status = STAT_OK;
			end
			CMD_APP_TEXT: begin
				imm_status = text_full ? STAT_FULL : STAT_OK;
			end
			CMD_APP_TERM: begin
				imm_status = term_full ? STAT_FULL : STAT_OK;
			end
			CMD_FWD: begin
				if (!term_empty) begin
					go_run = 1'b1;
				end else if (s_ext < tl_ext) begin
					imm_status = STAT_FOUND;
					imm_index  = request.start_index;
				end else begin
					imm_status = STAT_NONE;
				end
			end
			CMD_BWD: begin
				if (!term_empty) begin
					go_run = 1'b1;
				end else if (text_len_q == '0) begin
					imm_status = STAT_NONE;
				end else begin
					imm_status = STAT_FOUND;
					imm_index  = (s_ext < tl_ext) ? request.start_index : tl_m1[7:0];
				end
			end
			default: begin
				imm_status = STAT_OK;
			end
		endcase
	end

	// search datapath: memory read, cell row, hit tag
	assign issue     = (state_q == S_RUN) && (t_q < end_q);
	assign hit       = v_s2 && chain_hit;
	assign pos_full  = t_s2 - l_ext + CW'(1);

	always_comb begin
		finish     = 1'b0;
		fin_status = STAT_NONE;
		fin_index  = '0;
		if (state_q == S_RUN) begin
			if (hit && !bwd_q) begin
				finish     = 1'b1;
				fin_status = STAT_FOUND;
				fin_index  = pos_full[7:0];
			end else if (!issue && !v_s1 && !v_s2) begin
				finish     = 1'b1;
				fin_status = found_q ? STAT_FOUND : STAT_NONE;
				fin_index  = found_q ? last_pos_q : 8'd0;
			end
		end
	end

	assign ctl.load  = accept && (cmd == CMD_APP_TERM) && !term_full;
	assign ctl.step  = v_s1;
	assign ctl.flush = accept && go_run;
	assign ctl.data  = ctl.load ? request.data_byte : rd_s1;

	ciss_chain #(
		.TERM_DEPTH (TERM_DEPTH)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.term_len (term_len_q),
		.hit      (chain_hit)
	);

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_APP_TEXT) && !text_full) begin
			mem_q[text_len_q[AW-1:0]] <= request.data_byte;
		end
		if (issue) begin
			rd_s1 <= mem_q[t_q[AW-1:0]];
			t_s1  <= t_q;
		end
		if (v_s1) begin
			t_s2 <= t_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			text_len_q <= '0;
			term_len_q <= '0;
			t_q        <= '0;
			end_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			bwd_q      <= 1'b0;
			found_q    <= 1'b0;
			last_pos_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == S_RUN) && !finish;
			if (issue) begin
				t_q <= t_q + CW'(1);
			end
			if (accept) begin
				if (cmd == CMD_CLR_TEXT) begin
					text_len_q <= '0;
				end
				if (cmd == CMD_APP_TEXT && !text_full) begin
					text_len_q <= text_len_q + LW'(1);
				end
				if (cmd == CMD_CLR_TERM) begin
					term_len_q <= '0;
				end
				if (cmd == CMD_APP_TERM && !term_full) begin
					term_len_q <= term_len_q + TLW'(1);
				end
				if (go_run) begin
					state_q <= S_RUN;
					bwd_q   <= (cmd == CMD_BWD);
					found_q <= 1'b0;
					t_q     <= (cmd == CMD_BWD) ? '0 : s_ext;
					end_q   <= (cmd == CMD_BWD) ? bwd_end : tl_ext;
				end
			end
			if (hit && bwd_q) begin
				found_q    <= 1'b1;
				last_pos_q <= pos_full[7:0];
			end
			if (finish) begin
				state_q <= S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !go_run) || finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !go_run) begin
			out_status_q <= imm_status;
			out_index_q  <= imm_index;
		end else if (finish) begin
			out_status_q <= fin_status;
			out_index_q  <= fin_index;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_status_q;
	assign result.match_index = out_index_q;

endmodule
`default_nettype wire

// File: design/ciss_chk.sv
`default_nettype none
`include "assert_macros.svh"
module ciss_chk import ciss_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [2:0] in_command,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] out_status,
	input wire logic [7:0] out_index
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	`ASSERT_NOW(a_index_zero, out_valid && out_status != STAT_FOUND, out_index == 8'd0, "match_index set without a match")
	`ASSERT_NEXT(a_quick_result, in_acc && !(in_command == CMD_FWD || in_command == CMD_BWD), out_valid, "non-search request gave no result next cycle")
	`ASSERT_NEXT(a_clear_ok, in_acc && (in_command == CMD_CLR_TEXT || in_command == CMD_CLR_TERM), out_status == STAT_OK, "clear did not report accepted")
	`ASSERT_NOW(a_no_take_when_full, out_valid && !out_ready, !in_ready, "request taken while result slot blocked")
	`ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped before it was taken")

endmodule

bind case_insensitive_term_search ciss_chk u_ciss_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (request.valid),
	.in_ready   (request.ready),
	.in_command (request.command),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_status (result.status),
	.out_index  (result.match_index)
);
`default_nettype wire
